// File: hw/rtl/ffba_pkg.sv
// Shared types and codes of the first-fit block allocator.
`default_nettype none
package ffba_pkg;

    localparam int ADDR_BITS = 20;
    localparam logic [ADDR_BITS:0] ARENA_BYTES = {1'b1, {ADDR_BITS{1'b0}}};

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_RESIZE = 2'd2;
    localparam logic [1:0] REQ_CALLOC = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NONE    = 3'd1;
    localparam logic [2:0] ST_NOSPACE = 3'd2;
    localparam logic [2:0] ST_MAPPING = 3'd3;
    localparam logic [2:0] ST_BADH    = 3'd4;

    localparam logic [1:0] CFG_HEAP_LIMIT = 2'd0;
    localparam logic [1:0] CFG_INIT_HEAP  = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD  = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] request_bytes;
        logic [31:0] element_count;
        logic [19:0] block_handle;
        logic        handle_valid;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [19:0] result_handle;
        logic        needs_copy;
        logic [19:0] copy_bytes;
        logic [19:0] old_handle;
        logic [19:0] clear_bytes;
    } resp_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] offset;
        logic [ADDR_BITS-1:0] size;
        logic                 free;
    } entry_t;

    typedef enum logic {
        FIND_FREE,
        FIND_USED
    } probe_mode_t;

    typedef struct packed {
        logic                 active;
        probe_mode_t          mode;
        logic [ADDR_BITS:0]   key;
        logic                 found;
        logic                 grab;
        entry_t               hit;
        entry_t               prev;
        logic                 prev_valid;
        entry_t               next;
        logic                 next_valid;
        entry_t               last;
    } probe_t;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_WRITE,
        CMD_INSERT,
        CMD_DELETE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        entry_t  ent;
    } cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/ffba_cell.sv
// One table slot: holds a block entry, shifts on insert/delete, checks a passing probe.
`default_nettype none
module ffba_cell #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32,
    parameter int CELL_INDEX   = 0
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [$clog2(MAX_BLOCKS+1)-1:0]  count,
    input  ffba_pkg::cmd_t                   cmd,
    input  wire  [$clog2(MAX_BLOCKS)-1:0]    cmd_idx,
    input  ffba_pkg::entry_t                 left,
    input  ffba_pkg::entry_t                 right,
    input  ffba_pkg::probe_t                 probe_in,
    input  wire  [$clog2(MAX_BLOCKS)-1:0]    probe_idx_in,
    output ffba_pkg::entry_t                 entry,
    output ffba_pkg::probe_t                 probe_out,
    output logic [$clog2(MAX_BLOCKS)-1:0]    probe_idx_out
);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(CELL_INDEX);
    localparam logic [CW-1:0] MY_CNT = CW'(CELL_INDEX);
    localparam logic [ffba_pkg::ADDR_BITS:0] HDR = (ffba_pkg::ADDR_BITS+1)'(HEADER_BYTES);

    ffba_pkg::entry_t entry_reg, entry_next;
    ffba_pkg::probe_t probe_reg, probe_next;
    logic [IW-1:0]    pidx_reg, pidx_next;
    logic             in_use;
    logic             match;

    assign in_use = MY_CNT < count;

    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            ffba_pkg::CMD_WRITE:
            begin
                if (MY_IDX == cmd_idx)
                    entry_next = cmd.ent;
            end
            ffba_pkg::CMD_INSERT:
            begin
                if (MY_IDX == cmd_idx)
                    entry_next = cmd.ent;
                else if (MY_IDX > cmd_idx)
                    entry_next = left;
            end
            ffba_pkg::CMD_DELETE:
            begin
                if (MY_IDX >= cmd_idx)
                    entry_next = right;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_comb
    begin
        if (probe_in.mode == ffba_pkg::FIND_FREE)
            match = entry_reg.free && ({1'b0, entry_reg.size} >= probe_in.key);
        else
            match = !entry_reg.free && (({1'b0, entry_reg.offset} + HDR) == probe_in.key);
    end

    always_comb
    begin
        probe_next      = probe_in;
        pidx_next       = probe_idx_in;
        probe_next.last = entry_reg;
        probe_next.grab = 1'b0;
        if (probe_in.active)
        begin
            // neighbour after the hit slot
            if (probe_in.grab)
            begin
                probe_next.next       = entry_reg;
                probe_next.next_valid = in_use;
            end
            if (!probe_in.found && in_use && match)
            begin
                probe_next.found      = 1'b1;
                probe_next.hit        = entry_reg;
                probe_next.prev       = probe_in.last;
                probe_next.prev_valid = (CELL_INDEX != 0);
                probe_next.grab       = 1'b1;
                probe_next.next_valid = 1'b0;
                pidx_next             = MY_IDX;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        pidx_reg  <= pidx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            probe_reg <= '0;
        else
            probe_reg <= probe_next;
    end

    assign entry         = entry_reg;
    assign probe_out     = probe_reg;
    assign probe_idx_out = pidx_reg;

endmodule
`default_nettype wire

// File: hw/rtl/first_fit_block_allocator_unit.sv
// First-fit block allocator: request sequencer and chain of table slots.
// Keeps up to MAX_BLOCKS address-ordered blocks in a row of slots. A request that needs the
// table sends a probe down the slot chain (one slot per cycle) to find the first fitting
// free block or the block behind a handle; a resize that moves its block sends further
// probes. Splits, merges and appends then make their table changes one at a time. A new
// request is taken once the sequencer is idle; a finished answer waits in its own register.
// Configuration writes are taken every cycle and must only be made while idle.
`default_nettype none
module first_fit_block_allocator_unit #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32,
    parameter int ALIGN_BYTES  = 8
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                req_valid,
    output logic               req_stall,
    input  ffba_pkg::req_t     req,
    output logic               rsp_valid,
    input  wire                rsp_stall,
    output ffba_pkg::resp_t    rsp,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire  [1:0]         cfg_index,
    input  wire  [31:0]        cfg_data
);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AB = ffba_pkg::ADDR_BITS;
    localparam logic [AB-1:0] HDR20 = AB'(HEADER_BYTES);
    localparam logic [33:0]   HDR34 = 34'(HEADER_BYTES);
    localparam logic [33:0]   ALN34 = 34'(ALIGN_BYTES);
    localparam logic [32:0]   ALN_M = 33'(ALIGN_BYTES - 1);
    localparam logic [AB:0]   HDR21 = (AB+1)'(HEADER_BYTES);

    typedef enum logic [16:0] {
        S_IDLE    = 17'b00000000000000001,
        S_DECODE  = 17'b00000000000000010,
        S_MULT    = 17'b00000000000000100,
        S_OVF     = 17'b00000000000001000,
        S_ACHK    = 17'b00000000000010000,
        S_PROBE   = 17'b00000000000100000,
        S_WAIT    = 17'b00000000001000000,
        S_EVAL    = 17'b00000000010000000,
        S_GROWTH  = 17'b00000000100000000,
        S_CUT     = 17'b00000001000000000,
        S_SPLIT   = 17'b00000010000000000,
        S_TKDONE  = 17'b00000100000000000,
        S_RELWR   = 17'b00001000000000000,
        S_RELDEL  = 17'b00010000000000000,
        S_GROWWR  = 17'b00100000000000000,
        S_GROWDEL = 17'b01000000000000000,
        S_DONE    = 17'b10000000000000000
    } state_t;

    typedef enum logic [1:0] {
        CTX_ALLOC,
        CTX_FREE,
        CTX_RESIZE,
        CTX_REFREE
    } ctx_t;

    state_t                  state_reg, state_next;
    ctx_t                    ctx_reg, ctx_next;
    ffba_pkg::probe_mode_t   mode_reg, mode_next;
    ffba_pkg::req_t          rq_reg, rq_next;
    ffba_pkg::resp_t         work_reg, work_next;
    ffba_pkg::resp_t         out_reg, out_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             size_reg, size_next;
    logic [63:0]             prod_reg, prod_next;
    logic [32:0]             a_reg, a_next;
    logic [AB:0]             key_reg, key_next;
    logic                    mv_reg, mv_next;
    logic [AB-1:0]           old_reg, old_next;
    ffba_pkg::probe_t        pres_reg, pres_next;
    logic [IW-1:0]           pidx_reg, pidx_next;
    logic [IW-1:0]           cut_idx_reg, cut_idx_next;
    logic [AB-1:0]           cut_off_reg, cut_off_next;
    logic [AB-1:0]           cut_size_reg, cut_size_next;
    logic                    cut_new_reg, cut_new_next;
    logic [IW-1:0]           relw_idx_reg, relw_idx_next;
    ffba_pkg::entry_t        relw_ent_reg, relw_ent_next;
    logic [IW-1:0]           del_pos_reg, del_pos_next;
    logic [1:0]              del_n_reg, del_n_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AB:0]             heap_end_reg, heap_end_next;
    logic                    started_reg, started_next;
    logic [20:0]             limit_reg;
    logic [20:0]             init_reg;
    logic [31:0]             thr_reg;

    ffba_pkg::cmd_t          cmd;
    logic [IW-1:0]           cmd_idx;
    ffba_pkg::probe_t        inj;

    ffba_pkg::entry_t        ent  [MAX_BLOCKS];
    ffba_pkg::probe_t        pr   [MAX_BLOCKS+1];
    logic [IW-1:0]           pidx [MAX_BLOCKS+1];

    logic [32:0]             a_sz, a_rb;
    logic [AB:0]             lim;
    logic                    split_c;
    logic                    nf, pf;
    logic [AB-1:0]           tail;

    function automatic logic [AB:0] sat_key(input logic [32:0] v);
        sat_key = (v > 33'(ffba_pkg::ARENA_BYTES)) ? ffba_pkg::ARENA_BYTES : v[AB:0];
    endfunction

    assign a_sz = (33'(size_reg) + ALN_M) & ~ALN_M;
    assign a_rb = (33'(rq_reg.request_bytes) + ALN_M) & ~ALN_M;
    assign lim  = (limit_reg > 21'(ffba_pkg::ARENA_BYTES)) ? ffba_pkg::ARENA_BYTES
                                                            : limit_reg[AB:0];
    assign split_c = ((CW+1)'(count_reg) + (CW+1)'(cut_new_reg) < (CW+1)'(MAX_BLOCKS))
                     && (34'(cut_size_reg) >= 34'(a_reg) + HDR34 + ALN34);
    assign nf   = pres_reg.next_valid && pres_reg.next.free;
    assign pf   = pres_reg.prev_valid && pres_reg.prev.free;
    assign tail = nf ? (HDR20 + pres_reg.next.size) : '0;

    // slot chain
    assign pr[0]   = inj;
    assign pidx[0] = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_BLOCKS; k++)
        begin : g_cell
            ffba_pkg::entry_t lft, rgt;
            if (k == 0)
            begin : g_first
                assign lft = ent[k];
            end
            else
            begin : g_mid
                assign lft = ent[k-1];
            end
            if (k == MAX_BLOCKS - 1)
            begin : g_last
                assign rgt = ent[k];
            end
            else
            begin : g_inner
                assign rgt = ent[k+1];
            end
            ffba_cell #(
                .MAX_BLOCKS   (MAX_BLOCKS),
                .HEADER_BYTES (HEADER_BYTES),
                .CELL_INDEX   (k)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .count         (count_reg),
                .cmd           (cmd),
                .cmd_idx       (cmd_idx),
                .left          (lft),
                .right         (rgt),
                .probe_in      (pr[k]),
                .probe_idx_in  (pidx[k]),
                .entry         (ent[k]),
                .probe_out     (pr[k+1]),
                .probe_idx_out (pidx[k+1])
            );
        end
    endgenerate

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        ctx_next      = ctx_reg;
        mode_next     = mode_reg;
        rq_next       = rq_reg;
        work_next     = work_reg;
        out_next      = out_reg;
        out_valid_next = out_valid_reg;
        size_next     = size_reg;
        prod_next     = prod_reg;
        a_next        = a_reg;
        key_next      = key_reg;
        mv_next       = mv_reg;
        old_next      = old_reg;
        pres_next     = pres_reg;
        pidx_next     = pidx_reg;
        cut_idx_next  = cut_idx_reg;
        cut_off_next  = cut_off_reg;
        cut_size_next = cut_size_reg;
        cut_new_next  = cut_new_reg;
        relw_idx_next = relw_idx_reg;
        relw_ent_next = relw_ent_reg;
        del_pos_next  = del_pos_reg;
        del_n_next    = del_n_reg;
        count_next    = count_reg;
        heap_end_next = heap_end_reg;
        started_next  = started_reg;
        cmd           = '{op: ffba_pkg::CMD_NOP, ent: '0};
        cmd_idx       = '0;
        inj           = '0;

        if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    rq_next    = req;
                    work_next  = '0;
                    mv_next    = 1'b0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                size_next = rq_reg.request_bytes;
                key_next  = {1'b0, rq_reg.block_handle};
                mode_next = ffba_pkg::FIND_USED;
                case (rq_reg.req_type)
                    ffba_pkg::REQ_ALLOC:
                        state_next = S_ACHK;
                    ffba_pkg::REQ_FREE:
                    begin
                        if (!rq_reg.handle_valid)
                        begin
                            work_next.status = ffba_pkg::ST_NONE;
                            state_next       = S_DONE;
                        end
                        else
                        begin
                            ctx_next   = CTX_FREE;
                            state_next = S_PROBE;
                        end
                    end
                    ffba_pkg::REQ_CALLOC:
                    begin
                        if (rq_reg.request_bytes == '0 || rq_reg.element_count == '0)
                        begin
                            work_next.status = ffba_pkg::ST_NONE;
                            state_next       = S_DONE;
                        end
                        else
                            state_next = S_MULT;
                    end
                    default:
                    begin
                        if (!rq_reg.handle_valid)
                            state_next = S_ACHK;
                        else if (rq_reg.request_bytes == '0)
                        begin
                            ctx_next   = CTX_FREE;
                            state_next = S_PROBE;
                        end
                        else
                        begin
                            a_next     = a_rb;
                            ctx_next   = CTX_RESIZE;
                            state_next = S_PROBE;
                        end
                    end
                endcase
            end
            S_MULT:
            begin
                prod_next  = 64'(rq_reg.request_bytes) * 64'(rq_reg.element_count);
                state_next = S_OVF;
            end
            S_OVF:
            begin
                if (prod_reg[63:32] != '0)
                begin
                    work_next.status = ffba_pkg::ST_NOSPACE;
                    state_next       = S_DONE;
                end
                else
                begin
                    size_next  = prod_reg[31:0];
                    state_next = S_ACHK;
                end
            end
            S_ACHK:
            begin
                if (size_reg == '0)
                begin
                    work_next.status = ffba_pkg::ST_NONE;
                    state_next       = S_DONE;
                end
                else if (a_sz >= 33'(thr_reg))
                begin
                    work_next.status = ffba_pkg::ST_MAPPING;
                    state_next       = S_DONE;
                end
                else
                begin
                    a_next     = a_sz;
                    key_next   = sat_key(a_sz);
                    mode_next  = ffba_pkg::FIND_FREE;
                    ctx_next   = CTX_ALLOC;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                inj.active = 1'b1;
                inj.mode   = mode_reg;
                inj.key    = key_reg;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (pr[MAX_BLOCKS].active)
                begin
                    pres_next  = pr[MAX_BLOCKS];
                    pidx_next  = pidx[MAX_BLOCKS];
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                case (ctx_reg)
                    CTX_ALLOC:
                    begin
                        if (pres_reg.found)
                        begin
                            cut_idx_next  = pidx_reg;
                            cut_off_next  = pres_reg.hit.offset;
                            cut_size_next = pres_reg.hit.size;
                            cut_new_next  = 1'b0;
                            work_next.result_handle = pres_reg.hit.offset + HDR20;
                            state_next    = S_CUT;
                        end
                        else
                            state_next = S_GROWTH;
                    end
                    CTX_RESIZE:
                    begin
                        if (!pres_reg.found)
                        begin
                            work_next.status = ffba_pkg::ST_BADH;
                            state_next       = S_DONE;
                        end
                        else if (33'(pres_reg.hit.size) >= a_reg)
                        begin
                            cut_idx_next  = pidx_reg;
                            cut_off_next  = pres_reg.hit.offset;
                            cut_size_next = pres_reg.hit.size;
                            cut_new_next  = 1'b0;
                            state_next    = S_CUT;
                        end
                        else if (nf && (34'(pres_reg.hit.size) + HDR34 +
                                        34'(pres_reg.next.size) >= 34'(a_reg)))
                        begin
                            cut_idx_next  = pidx_reg;
                            cut_off_next  = pres_reg.hit.offset;
                            cut_size_next = pres_reg.hit.size + HDR20 + pres_reg.next.size;
                            cut_new_next  = 1'b0;
                            state_next    = S_GROWWR;
                        end
                        else if (a_reg >= 33'(thr_reg))
                        begin
                            work_next.status     = ffba_pkg::ST_MAPPING;
                            work_next.copy_bytes = pres_reg.hit.size;
                            work_next.old_handle = rq_reg.block_handle;
                            state_next           = S_DONE;
                        end
                        else
                        begin
                            // move: find new room first, free the old block after
                            mv_next    = 1'b1;
                            old_next   = pres_reg.hit.size;
                            ctx_next   = CTX_ALLOC;
                            key_next   = sat_key(a_reg);
                            mode_next  = ffba_pkg::FIND_FREE;
                            state_next = S_PROBE;
                        end
                    end
                    default:
                    begin
                        if (!pres_reg.found)
                        begin
                            if (ctx_reg == CTX_FREE)
                                work_next.status = ffba_pkg::ST_BADH;
                            else
                            begin
                                work_next.status     = ffba_pkg::ST_OK;
                                work_next.needs_copy = 1'b1;
                                work_next.copy_bytes = old_reg;
                                work_next.old_handle = rq_reg.block_handle;
                            end
                            state_next = S_DONE;
                        end
                        else
                        begin
                            if (pf)
                            begin
                                relw_idx_next = pidx_reg - IW'(1);
                                relw_ent_next = '{offset: pres_reg.prev.offset,
                                                  size: pres_reg.prev.size + HDR20 +
                                                        pres_reg.hit.size + tail,
                                                  free: 1'b1};
                                del_pos_next  = pidx_reg;
                                del_n_next    = nf ? 2'd2 : 2'd1;
                            end
                            else
                            begin
                                relw_idx_next = pidx_reg;
                                relw_ent_next = '{offset: pres_reg.hit.offset,
                                                  size: pres_reg.hit.size + tail,
                                                  free: 1'b1};
                                del_pos_next  = pidx_reg + IW'(1);
                                del_n_next    = nf ? 2'd1 : 2'd0;
                            end
                            state_next = S_RELWR;
                        end
                    end
                endcase
            end
            S_GROWTH:
            begin
                if (!started_reg)
                begin
                    if (init_reg > 21'(lim))
                    begin
                        work_next.status        = ffba_pkg::ST_NOSPACE;
                        work_next.result_handle = '0;
                        state_next              = S_DONE;
                    end
                    else
                    begin
                        started_next  = 1'b1;
                        heap_end_next = heap_end_reg + init_reg[AB:0];
                        if (init_reg >= 21'(HEADER_BYTES) &&
                            33'(init_reg - 21'(HEADER_BYTES)) >= a_reg)
                        begin
                            // first block of the initial heap fits: insert and take it
                            cut_idx_next  = count_reg[IW-1:0];
                            cut_off_next  = heap_end_reg[AB-1:0];
                            cut_size_next = AB'(init_reg - 21'(HEADER_BYTES));
                            cut_new_next  = 1'b1;
                            work_next.result_handle = heap_end_reg[AB-1:0] + HDR20;
                            state_next    = S_CUT;
                        end
                        else if (init_reg >= 21'(HEADER_BYTES))
                        begin
                            cmd.op     = ffba_pkg::CMD_INSERT;
                            cmd.ent    = '{offset: heap_end_reg[AB-1:0],
                                           size: AB'(init_reg - 21'(HEADER_BYTES)),
                                           free: 1'b1};
                            cmd_idx    = count_reg[IW-1:0];
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
                else if (count_reg == CW'(MAX_BLOCKS) ||
                         34'(heap_end_reg) + HDR34 + 34'(a_reg) > 34'(lim))
                begin
                    work_next.status        = ffba_pkg::ST_NOSPACE;
                    work_next.result_handle = '0;
                    state_next              = S_DONE;
                end
                else
                begin
                    cmd.op        = ffba_pkg::CMD_INSERT;
                    cmd.ent       = '{offset: heap_end_reg[AB-1:0],
                                      size: a_reg[AB-1:0], free: 1'b0};
                    cmd_idx       = count_reg[IW-1:0];
                    count_next    = count_reg + CW'(1);
                    heap_end_next = heap_end_reg + HDR21 + a_reg[AB:0];
                    work_next.result_handle = heap_end_reg[AB-1:0] + HDR20;
                    state_next    = S_TKDONE;
                end
            end
            S_CUT:
            begin
                cmd.op  = cut_new_reg ? ffba_pkg::CMD_INSERT : ffba_pkg::CMD_WRITE;
                cmd.ent = '{offset: cut_off_reg,
                            size: split_c ? a_reg[AB-1:0] : cut_size_reg,
                            free: 1'b0};
                cmd_idx = cut_idx_reg;
                if (cut_new_reg)
                    count_next = count_reg + CW'(1);
                if (split_c)
                    state_next = S_SPLIT;
                else if (ctx_reg == CTX_RESIZE)
                begin
                    work_next.status        = ffba_pkg::ST_OK;
                    work_next.result_handle = rq_reg.block_handle;
                    state_next              = S_DONE;
                end
                else
                    state_next = S_TKDONE;
            end
            S_SPLIT:
            begin
                cmd.op     = ffba_pkg::CMD_INSERT;
                cmd.ent    = '{offset: cut_off_reg + HDR20 + a_reg[AB-1:0],
                               size: cut_size_reg - a_reg[AB-1:0] - HDR20,
                               free: 1'b1};
                cmd_idx    = cut_idx_reg + IW'(1);
                count_next = count_reg + CW'(1);
                if (ctx_reg == CTX_RESIZE)
                begin
                    work_next.status        = ffba_pkg::ST_OK;
                    work_next.result_handle = rq_reg.block_handle;
                    state_next              = S_DONE;
                end
                else
                    state_next = S_TKDONE;
            end
            S_TKDONE:
            begin
                if (mv_reg)
                begin
                    key_next   = {1'b0, rq_reg.block_handle};
                    mode_next  = ffba_pkg::FIND_USED;
                    ctx_next   = CTX_REFREE;
                    state_next = S_PROBE;
                end
                else
                begin
                    work_next.status = ffba_pkg::ST_OK;
                    if (rq_reg.req_type == ffba_pkg::REQ_CALLOC)
                        work_next.clear_bytes = a_reg[AB-1:0];
                    state_next = S_DONE;
                end
            end
            S_RELWR, S_RELDEL:
            begin
                if (state_reg == S_RELWR)
                begin
                    cmd.op  = ffba_pkg::CMD_WRITE;
                    cmd.ent = relw_ent_reg;
                    cmd_idx = relw_idx_reg;
                end
                else
                begin
                    cmd.op     = ffba_pkg::CMD_DELETE;
                    cmd_idx    = del_pos_reg;
                    count_next = count_reg - CW'(1);
                    del_n_next = del_n_reg - 2'd1;
                end
                if ((state_reg == S_RELWR && del_n_reg != 2'd0) ||
                    (state_reg == S_RELDEL && del_n_reg == 2'd2))
                    state_next = S_RELDEL;
                else
                begin
                    work_next.status = ffba_pkg::ST_OK;
                    if (ctx_reg == CTX_REFREE)
                    begin
                        work_next.needs_copy = 1'b1;
                        work_next.copy_bytes = old_reg;
                        work_next.old_handle = rq_reg.block_handle;
                    end
                    else
                        work_next.result_handle = '0;
                    state_next = S_DONE;
                end
            end
            S_GROWWR:
            begin
                cmd.op     = ffba_pkg::CMD_WRITE;
                cmd.ent    = '{offset: cut_off_reg, size: cut_size_reg, free: 1'b0};
                cmd_idx    = cut_idx_reg;
                state_next = S_GROWDEL;
            end
            S_GROWDEL:
            begin
                cmd.op     = ffba_pkg::CMD_DELETE;
                cmd_idx    = cut_idx_reg + IW'(1);
                count_next = count_reg - CW'(1);
                state_next = S_CUT;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = work_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            heap_end_reg  <= '0;
            started_reg   <= 1'b0;
            limit_reg     <= 21'h100000;
            init_reg      <= 21'h020000;
            thr_reg       <= 32'h00020000;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            heap_end_reg  <= heap_end_next;
            started_reg   <= started_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    ffba_pkg::CFG_HEAP_LIMIT: limit_reg <= cfg_data[20:0];
                    ffba_pkg::CFG_INIT_HEAP:  init_reg  <= cfg_data[20:0];
                    ffba_pkg::CFG_THRESHOLD:  thr_reg   <= cfg_data;
                    default:                  thr_reg   <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ctx_reg      <= ctx_next;
        mode_reg     <= mode_next;
        rq_reg       <= rq_next;
        work_reg     <= work_next;
        out_reg      <= out_next;
        size_reg     <= size_next;
        prod_reg     <= prod_next;
        a_reg        <= a_next;
        key_reg      <= key_next;
        mv_reg       <= mv_next;
        old_reg      <= old_next;
        pres_reg     <= pres_next;
        pidx_reg     <= pidx_next;
        cut_idx_reg  <= cut_idx_next;
        cut_off_reg  <= cut_off_next;
        cut_size_reg <= cut_size_next;
        cut_new_reg  <= cut_new_next;
        relw_idx_reg <= relw_idx_next;
        relw_ent_reg <= relw_ent_next;
        del_pos_reg  <= del_pos_next;
        del_n_reg    <= del_n_next;
    end

endmodule
`default_nettype wire
